// ----- rtl/core/lzwc_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants for the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
`default_nettype none
package lzwc_pkg;
   localparam int CODE_WIDTH = 12;
   localparam int CODE_LIMIT = 4095;
   localparam int FIRST_FREE = 256;
   localparam int BYTE_WIDTH = 8;
endpackage
`default_nettype wire

// ----- rtl/core/lzwc_queue.sv -----
// ----------------------------------------------------------------------------
// lzwc_queue
// Two-entry queue with valid/stall on the write side and valid/ready on the
// read side.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwc_queue #(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_stall,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_stall = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = slot_ff[rp_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/lzwc_engine.sv -----
// ----------------------------------------------------------------------------
// lzwc_engine
// Dictionary search and update: hashed table with linear probing, code
// emission, and a clearing sweep after reset and after each stream.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwc_engine #(
   parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH,
   parameter int CODE_LIMIT = lzwc_pkg::CODE_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [lzwc_pkg::BYTE_WIDTH:0] in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [CODE_WIDTH:0]   out_data
);
   localparam int BW    = lzwc_pkg::BYTE_WIDTH;
   localparam int KW    = CODE_WIDTH + BW;
   localparam int EW    = 1 + KW + CODE_WIDTH;
   localparam int DEPTH = 1 << CODE_WIDTH;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_MISS  = 6'b010000,
      ST_LAST  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CODE_WIDTH-1:0] prefix_ff, prefix_in;
   logic                  held_ff, held_in;
   logic [CODE_WIDTH-1:0] next_ff, next_in;
   logic [CODE_WIDTH-1:0] addr_ff, addr_in;
   logic [BW-1:0]         byte_ff, byte_in;
   logic                  eos_ff, eos_in;
   logic [EW-1:0]         rd_ff;

   logic [EW-1:0]         mem [DEPTH];
   logic                  we;
   logic [CODE_WIDTH-1:0] wa;
   logic [EW-1:0]         wd;

   logic [KW-1:0]         key;
   logic                  rd_vld;
   logic [KW-1:0]         rd_key;
   logic [CODE_WIDTH-1:0] rd_code;

   assign key     = {prefix_ff, byte_ff};
   assign rd_vld  = rd_ff[EW-1];
   assign rd_key  = rd_ff[EW-2 -: KW];
   assign rd_code = rd_ff[CODE_WIDTH-1:0];
   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      prefix_in = prefix_ff;
      held_in   = held_ff;
      next_in   = next_ff;
      addr_in   = addr_ff;
      byte_in   = byte_ff;
      eos_in    = eos_ff;
      we        = 1'b0;
      wa        = addr_ff;
      wd        = {1'b1, key, next_ff};
      out_valid = 1'b0;
      out_data  = {1'b0, prefix_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            we      = 1'b1;
            wd      = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == {CODE_WIDTH{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_valid) begin
               byte_in = in_data[BW-1:0];
               eos_in  = in_data[BW];
               if (!held_ff) begin
                  prefix_in = {{(CODE_WIDTH-BW){1'b0}}, in_data[BW-1:0]};
                  held_in   = 1'b1;
                  state_in  = in_data[BW] ? ST_LAST : ST_IDLE;
               end else begin
                  addr_in  = prefix_ff ^ {in_data[BW-1:0], {(CODE_WIDTH-BW){1'b0}}};
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_vld && rd_key == key) begin
               prefix_in = rd_code;
               state_in  = eos_ff ? ST_LAST : ST_IDLE;
            end else if (rd_vld) begin
               addr_in  = addr_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            out_valid = 1'b1;
            if (!out_stall) begin
               if (next_ff < CODE_WIDTH'(CODE_LIMIT)) begin
                  we      = 1'b1;
                  next_in = next_ff + 1'b1;
               end
               prefix_in = {{(CODE_WIDTH-BW){1'b0}}, byte_ff};
               state_in  = eos_ff ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST: begin
            out_valid = 1'b1;
            out_data  = {1'b1, prefix_ff};
            if (!out_stall) begin
               prefix_in = '0;
               held_in   = 1'b0;
               next_in   = CODE_WIDTH'(lzwc_pkg::FIRST_FREE);
               addr_in   = '0;
               state_in  = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         prefix_ff <= '0;
         held_ff   <= 1'b0;
         next_ff   <= CODE_WIDTH'(lzwc_pkg::FIRST_FREE);
         addr_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         held_ff   <= held_in;
         next_ff   <= next_in;
         addr_ff   <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[addr_ff];
   end
endmodule
`default_nettype wire

// ----- rtl/core/lzw_compressor_12bit.sv -----
// ----------------------------------------------------------------------------
// lzw_compressor_12bit
// LZW compressor: bytes in, dictionary codes out.
// ----------------------------------------------------------------------------
// One byte per transfer in, up to two codes per byte out. The first byte of a
// stream is only held as the prefix. Each later byte is looked up in the hash
// table by a registered read of the dictionary memory; a collision probes the
// next entry, and a miss emits the prefix code and adds a new entry while free
// codes remain. After reset and after the last code of every stream, the
// dictionary is cleared by a sweep of all 2**CODE_WIDTH entries (4096 at
// default), during which the engine takes no byte; the front queue holds two.
`default_nettype none
module lzw_compressor_12bit #(
   parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH,
   parameter int CODE_LIMIT = lzwc_pkg::CODE_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_stream,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_WIDTH-1:0] rsp_code_word,
   output logic                  rsp_last_code
);
   localparam int BW = lzwc_pkg::BYTE_WIDTH;

   logic          q_valid, q_ready;
   logic [BW:0]   q_data;
   logic          e_valid, e_stall;
   logic [CODE_WIDTH:0] e_data, o_data;
   logic          o_ready;

   lzwc_queue #(.WIDTH(BW + 1)) u_front (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_stall (req_stall),
      .wr_data  ({req_end_of_stream, req_data_byte}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   lzwc_engine #(.CODE_WIDTH(CODE_WIDTH), .CODE_LIMIT(CODE_LIMIT)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (e_valid),
      .out_stall (e_stall),
      .out_data  (e_data)
   );

   lzwc_queue #(.WIDTH(CODE_WIDTH + 1)) u_back (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (e_valid),
      .wr_stall (e_stall),
      .wr_data  (e_data),
      .rd_valid (rsp_valid),
      .rd_ready (o_ready),
      .rd_data  (o_data)
   );

   assign o_ready       = !rsp_stall;
   assign rsp_code_word = o_data[CODE_WIDTH-1:0];
   assign rsp_last_code = o_data[CODE_WIDTH];
endmodule
`default_nettype wire
